/* hdl/obpr_pkg.sv */
// ----------------------------------------------------------------------------
// Oriented box point rejector package
// Shared types, codes and constants for the box table, the box test datapath
// and the sequencer.
// ----------------------------------------------------------------------------
package obpr_pkg;

	// Default depth of the box table.
	localparam int MAX_BOXES_DEF = 16;

	// Configuration port geometry.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Item kinds carried in the func field.
	localparam logic [1:0] FUNC_START  = 2'd0;
	localparam logic [1:0] FUNC_APPEND = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;
	localparam logic [1:0] FUNC_POINT  = 2'd3;

	// Register indexes, taken from paddr[2].
	localparam logic REG_MARGIN  = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [30:0] MARGIN_RST  = 31'd6554;
	localparam logic [31:0] TIMEOUT_RST = 32'd1000;

	// One stored box: centre, half-extent plus margin in Q16.17, heading.
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic        [32:0] hx;
		logic        [32:0] hy;
		logic        [32:0] hz;
		logic signed [15:0] cos_h;
		logic signed [15:0] sin_h;
	} box_entry_t;

	// Steps of the shared box test datapath.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_DIFF,
		OP_MUL0,
		OP_MUL1,
		OP_MUL2,
		OP_MUL3,
		OP_SUBV
	} dp_op_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic   load_point;
		dp_op_t op;
	} dp_ctrl_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_DIFF,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_SUBV,
		ST_CHECK,
		ST_PUSH
	} state_t;

endpackage

/* hdl/obpr_box_mem.sv */
// ----------------------------------------------------------------------------
// Box table memory
// One write port and one registered read port holding the stored boxes.
// ----------------------------------------------------------------------------
module obpr_box_mem #(
	parameter int MAX_BOXES = obpr_pkg::MAX_BOXES_DEF,
	localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [IdxW-1:0]        wr_addr,
	input  obpr_pkg::box_entry_t   wr_data,
	input  logic                   rd_en,
	input  logic [IdxW-1:0]        rd_addr,
	output obpr_pkg::box_entry_t   rd_data
);

	obpr_pkg::box_entry_t mem [MAX_BOXES];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hdl/obpr_box_test.sv */
// ----------------------------------------------------------------------------
// Box test datapath
// Rotates a point's offset from one box centre through a single shared
// 33x16 multiplier and checks the result against the box half-extents.
// ----------------------------------------------------------------------------
module obpr_box_test (
	input  logic                  clk,
	input  obpr_pkg::dp_ctrl_t    ctrl,
	input  logic signed [31:0]    pos_x,
	input  logic signed [31:0]    pos_y,
	input  logic signed [31:0]    pos_z,
	input  obpr_pkg::box_entry_t  entry,
	output logic                  in_box
);

	logic signed [31:0] px_q;
	logic signed [31:0] py_q;
	logic signed [31:0] pz_q;
	logic signed [32:0] dx_q;
	logic signed [32:0] dy_q;
	logic signed [32:0] dz_q;
	logic signed [48:0] prod_q;
	logic signed [48:0] acc_q;
	logic signed [49:0] u_q;
	logic signed [49:0] v_q;
	logic               dz_ok_q;

	logic signed [32:0] mul_a;
	logic signed [15:0] mul_b;
	logic signed [48:0] product;
	logic        [32:0] dz_mag;
	logic        [49:0] u_mag;
	logic        [49:0] v_mag;

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = dx_q;
		mul_b = entry.cos_h;
		case (ctrl.op)
			obpr_pkg::OP_MUL0: begin
				mul_a = dx_q;
				mul_b = entry.cos_h;
			end
			obpr_pkg::OP_MUL1: begin
				mul_a = dy_q;
				mul_b = entry.sin_h;
			end
			obpr_pkg::OP_MUL2: begin
				mul_a = dy_q;
				mul_b = entry.cos_h;
			end
			obpr_pkg::OP_MUL3: begin
				mul_a = dx_q;
				mul_b = entry.sin_h;
			end
			default: begin
				mul_a = dx_q;
				mul_b = entry.cos_h;
			end
		endcase
		product = mul_a * mul_b;
	end

	assign dz_mag = dz_q[32] ? 33'(-dz_q) : 33'(dz_q);

	// Point capture and the step sequence over one box.
	always_ff @(posedge clk) begin
		if (ctrl.load_point) begin
			px_q <= pos_x;
			py_q <= pos_y;
			pz_q <= pos_z;
		end
		case (ctrl.op)
			obpr_pkg::OP_DIFF: begin
				dx_q <= {px_q[31], px_q} - {entry.cx[31], entry.cx};
				dy_q <= {py_q[31], py_q} - {entry.cy[31], entry.cy};
				dz_q <= {pz_q[31], pz_q} - {entry.cz[31], entry.cz};
			end
			obpr_pkg::OP_MUL0: begin
				prod_q  <= product;
				dz_ok_q <= ({dz_mag, 1'b0} <= {1'b0, entry.hz});
			end
			obpr_pkg::OP_MUL1: begin
				prod_q <= product;
				acc_q  <= prod_q;
			end
			obpr_pkg::OP_MUL2: begin
				prod_q <= product;
				u_q    <= {acc_q[48], acc_q} + {prod_q[48], prod_q};
			end
			obpr_pkg::OP_MUL3: begin
				prod_q <= product;
				acc_q  <= prod_q;
			end
			obpr_pkg::OP_SUBV: begin
				v_q <= {acc_q[48], acc_q} - {prod_q[48], prod_q};
			end
			default: begin
			end
		endcase
	end

	// Bounds check of the rotated offsets against half-extent times 2^13.
	always_comb begin
		u_mag  = u_q[49] ? 50'(-u_q) : 50'(u_q);
		v_mag  = v_q[49] ? 50'(-v_q) : 50'(v_q);
		in_box = dz_ok_q
			&& (u_mag <= {4'b0, entry.hx, 13'b0})
			&& (v_mag <= {4'b0, entry.hy, 13'b0});
	end

endmodule

/* hdl/oriented_box_point_rejector.sv */
// ----------------------------------------------------------------------------
// Oriented box point rejector
// Keeps a table of yaw-oriented boxes and drops points that fall inside one.
//
// Usage: items arrive on the in_* channel with valid/ready. A start item
// clears the box list and its age, an append item stores one box (ignored
// once the table is full), a tick item ages the list, and a point item
// produces exactly one transfer on the out_* channel with keep and
// filter_active. Start, append and tick items leave in_ready high. A
// point item keeps in_ready low until its result is loaded into the
// output register, so the next item waits for it. The point is tested
// against the stored boxes in order until a hit or the end of the list:
// each box takes a table read, an offset subtract, four passes through
// the one 33x16 multiplier, a subtract and a compare. A stale or empty
// list means that no box is tested before the result is pushed.
// The result sits in an output register; while the receiver stalls, the
// block keeps taking non-point items, and a point waits at its end until
// the output register is free. Reset empties the list, zeroes the age,
// marks no list as received and loads the register defaults. The box
// table has no reset and needs no clearing pass. Registers sit on an APB
// port: margin at 0x0, timeout_ticks at 0x4.
// ----------------------------------------------------------------------------
module oriented_box_point_rejector #(
	parameter int MAX_BOXES = obpr_pkg::MAX_BOXES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input item channel.
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    func,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	input  logic signed [31:0]            pos_z,
	input  logic [30:0]                   size_x,
	input  logic [30:0]                   size_y,
	input  logic [30:0]                   size_z,
	input  logic signed [15:0]            cos_heading,
	input  logic signed [15:0]            sin_heading,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          keep,
	output logic                          filter_active,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [obpr_pkg::PADDR_W-1:0]  paddr,
	input  logic [obpr_pkg::PDATA_W-1:0]  pwdata,
	output logic [obpr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CntW = $clog2(MAX_BOXES + 1);

	obpr_pkg::state_t     state_q;
	obpr_pkg::state_t     state_d;
	logic [IdxW-1:0]      idx_q;
	logic [CntW-1:0]      count_q;
	logic [31:0]          age_q;
	logic                 recv_q;
	logic [30:0]          margin_q;
	logic [31:0]          timeout_q;
	logic                 res_keep_q;
	logic                 res_active_q;
	logic                 out_valid_q;
	logic                 keep_q;
	logic                 active_q;

	logic                 accept_in;
	logic                 cfg_write;
	logic                 active_now;
	logic                 table_full;
	logic                 last_box;
	logic                 hit;
	logic                 push_out;
	logic                 mem_wr;
	logic                 mem_rd;
	obpr_pkg::box_entry_t new_entry;
	obpr_pkg::box_entry_t rd_entry;
	obpr_pkg::dp_ctrl_t   dp_ctrl;

	assign in_ready   = (state_q == obpr_pkg::ST_IDLE);
	assign accept_in  = in_valid && in_ready;
	assign active_now = recv_q && (age_q < timeout_q);
	assign table_full = (count_q >= CntW'(MAX_BOXES));
	assign last_box   = (CntW'({1'b0, idx_q}) + CntW'(1) == count_q);
	assign mem_wr     = accept_in && (func == obpr_pkg::FUNC_APPEND) && !table_full;
	assign mem_rd     = (state_q == obpr_pkg::ST_READ);

	// Box entry built from an append item; half-extent held as size + 2*margin.
	always_comb begin
		new_entry.cx    = pos_x;
		new_entry.cy    = pos_y;
		new_entry.cz    = pos_z;
		new_entry.hx    = {2'b0, size_x} + {1'b0, margin_q, 1'b0};
		new_entry.hy    = {2'b0, size_y} + {1'b0, margin_q, 1'b0};
		new_entry.hz    = {2'b0, size_z} + {1'b0, margin_q, 1'b0};
		new_entry.cos_h = cos_heading;
		new_entry.sin_h = sin_heading;
	end

	obpr_box_mem #(
		.MAX_BOXES(MAX_BOXES)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_wr),
		.wr_addr(count_q[IdxW-1:0]),
		.wr_data(new_entry),
		.rd_en  (mem_rd),
		.rd_addr(idx_q),
		.rd_data(rd_entry)
	);

	obpr_box_test u_test (
		.clk   (clk),
		.ctrl  (dp_ctrl),
		.pos_x (pos_x),
		.pos_y (pos_y),
		.pos_z (pos_z),
		.entry (rd_entry),
		.in_box(hit)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= obpr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath step for each state.
	always_comb begin
		state_d            = state_q;
		dp_ctrl.load_point = 1'b0;
		dp_ctrl.op         = obpr_pkg::OP_NONE;
		push_out           = 1'b0;
		case (state_q)
			obpr_pkg::ST_IDLE: begin
				if (accept_in && (func == obpr_pkg::FUNC_POINT)) begin
					dp_ctrl.load_point = 1'b1;
					if (active_now && (count_q != '0)) begin
						state_d = obpr_pkg::ST_READ;
					end else begin
						state_d = obpr_pkg::ST_PUSH;
					end
				end
			end
			obpr_pkg::ST_READ: begin
				state_d = obpr_pkg::ST_DIFF;
			end
			obpr_pkg::ST_DIFF: begin
				dp_ctrl.op = obpr_pkg::OP_DIFF;
				state_d    = obpr_pkg::ST_MUL0;
			end
			obpr_pkg::ST_MUL0: begin
				dp_ctrl.op = obpr_pkg::OP_MUL0;
				state_d    = obpr_pkg::ST_MUL1;
			end
			obpr_pkg::ST_MUL1: begin
				dp_ctrl.op = obpr_pkg::OP_MUL1;
				state_d    = obpr_pkg::ST_MUL2;
			end
			obpr_pkg::ST_MUL2: begin
				dp_ctrl.op = obpr_pkg::OP_MUL2;
				state_d    = obpr_pkg::ST_MUL3;
			end
			obpr_pkg::ST_MUL3: begin
				dp_ctrl.op = obpr_pkg::OP_MUL3;
				state_d    = obpr_pkg::ST_SUBV;
			end
			obpr_pkg::ST_SUBV: begin
				dp_ctrl.op = obpr_pkg::OP_SUBV;
				state_d    = obpr_pkg::ST_CHECK;
			end
			obpr_pkg::ST_CHECK: begin
				if (hit || last_box) begin
					state_d = obpr_pkg::ST_PUSH;
				end else begin
					state_d = obpr_pkg::ST_READ;
				end
			end
			obpr_pkg::ST_PUSH: begin
				if (!out_valid_q || out_ready) begin
					push_out = 1'b1;
					state_d  = obpr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = obpr_pkg::ST_IDLE;
			end
		endcase
	end

	// List bookkeeping, box index and the pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			age_q        <= '0;
			recv_q       <= 1'b0;
			idx_q        <= '0;
			res_keep_q   <= 1'b1;
			res_active_q <= 1'b0;
		end else begin
			if (accept_in) begin
				case (func)
					obpr_pkg::FUNC_START: begin
						count_q <= '0;
						age_q   <= '0;
						recv_q  <= 1'b1;
					end
					obpr_pkg::FUNC_APPEND: begin
						if (!table_full) begin
							count_q <= count_q + CntW'(1);
						end
					end
					obpr_pkg::FUNC_TICK: begin
						if (age_q != '1) begin
							age_q <= age_q + 32'd1;
						end
					end
					obpr_pkg::FUNC_POINT: begin
						idx_q        <= '0;
						res_keep_q   <= 1'b1;
						res_active_q <= active_now;
					end
					default: begin
					end
				endcase
			end
			if (state_q == obpr_pkg::ST_CHECK) begin
				if (hit) begin
					res_keep_q <= 1'b0;
				end else if (!last_box) begin
					idx_q <= idx_q + IdxW'(1);
				end
			end
		end
	end

	// Output register; a new result loads only when the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			keep_q      <= 1'b1;
			active_q    <= 1'b0;
		end else if (push_out) begin
			out_valid_q <= 1'b1;
			keep_q      <= res_keep_q;
			active_q    <= res_active_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign keep          = keep_q;
	assign filter_active = active_q;

	// Configuration registers; a write transfer completes in the access cycle.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q  <= obpr_pkg::MARGIN_RST;
			timeout_q <= obpr_pkg::TIMEOUT_RST;
		end else if (cfg_write) begin
			case (paddr[2])
				obpr_pkg::REG_MARGIN:  margin_q  <= pwdata[30:0];
				obpr_pkg::REG_TIMEOUT: timeout_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (paddr[2])
			obpr_pkg::REG_MARGIN:  prdata = {1'b0, margin_q};
			obpr_pkg::REG_TIMEOUT: prdata = timeout_q;
			default:               prdata = '0;
		endcase
	end

endmodule

/* sim/rejector_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oriented box point rejector checker
// Watches the item, result and register ports of the rejector, keeps its own
// copy of the box table, the list age and the registers, works out the
// keep and filter_active verdict of every accepted point and compares each
// result transfer with the oldest verdict still outstanding.
// ----------------------------------------------------------------------------
module rejector_checker #(
	parameter int MAX_BOXES = obpr_pkg::MAX_BOXES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic signed [31:0]           pos_x,
	input  logic signed [31:0]           pos_y,
	input  logic signed [31:0]           pos_z,
	input  logic [30:0]                  size_x,
	input  logic [30:0]                  size_y,
	input  logic [30:0]                  size_z,
	input  logic signed [15:0]           cos_heading,
	input  logic signed [15:0]           sin_heading,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         keep,
	input  logic                         filter_active,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [obpr_pkg::PADDR_W-1:0] paddr,
	input  logic [obpr_pkg::PDATA_W-1:0] pwdata,
	output int                           fail_count,
	output int                           pending,
	output int                           points_seen,
	output int                           points_dropped,
	output int                           points_passive
);

	// Verdict that one point item must produce.
	typedef struct packed {
		logic keep;
		logic active;
	} verdict_t;

	// Shadow of the block state and registers.
	obpr_pkg::box_entry_t boxes [MAX_BOXES];
	int                   box_count;
	logic [31:0]          age;
	logic                 list_seen;
	logic [30:0]          margin_q;
	logic [31:0]          timeout_q;
	verdict_t             verdicts [$];

	// Prints one line per mismatch and counts it.
	task automatic log_mismatch(input string what);
		fail_count++;
		$display("ERROR %0t ns: %s", $time, what);
	endtask

	function automatic longint magnitude(input longint a);
		return (a < 0) ? -a : a;
	endfunction

	// Exact box test: rotate the offset by each heading and bound-check it.
	function automatic verdict_t test_point(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz);
		verdict_t r;
		longint   dx, dy, dz, c, s, u, v;
		int       k;
		r.active = list_seen && (age < timeout_q);
		r.keep = 1'b1;
		k = 0;
		while (r.active && r.keep && k < box_count) begin
			dx = longint'(px) - longint'($signed(boxes[k].cx));
			dy = longint'(py) - longint'($signed(boxes[k].cy));
			dz = longint'(pz) - longint'($signed(boxes[k].cz));
			c = longint'($signed(boxes[k].cos_h));
			s = longint'($signed(boxes[k].sin_h));
			u = dx * c + dy * s;
			v = dy * c - dx * s;
			if (magnitude(u) <= longint'(boxes[k].hx) * 8192 &&
					magnitude(v) <= longint'(boxes[k].hy) * 8192 &&
					2 * magnitude(dz) <= longint'(boxes[k].hz)) begin
				r.keep = 1'b0;
			end
			k++;
		end
		return r;
	endfunction

	// Applies one accepted item to the shadow state.
	task automatic apply_item();
		verdict_t exp_v;
		case (func)
			obpr_pkg::FUNC_START: begin
				box_count = 0;
				age = '0;
				list_seen = 1'b1;
			end
			obpr_pkg::FUNC_APPEND: begin
				// A full table ignores the append.
				if (box_count < MAX_BOXES) begin
					boxes[box_count].cx = pos_x;
					boxes[box_count].cy = pos_y;
					boxes[box_count].cz = pos_z;
					boxes[box_count].hx = 33'(size_x) + {1'b0, margin_q, 1'b0};
					boxes[box_count].hy = 33'(size_y) + {1'b0, margin_q, 1'b0};
					boxes[box_count].hz = 33'(size_z) + {1'b0, margin_q, 1'b0};
					boxes[box_count].cos_h = cos_heading;
					boxes[box_count].sin_h = sin_heading;
					box_count++;
				end
			end
			obpr_pkg::FUNC_TICK: begin
				if (age != '1) begin
					age = age + 32'd1;
				end
			end
			obpr_pkg::FUNC_POINT: begin
				exp_v = test_point(pos_x, pos_y, pos_z);
				verdicts.insert(verdicts.size(), exp_v);
				points_seen++;
				if (!exp_v.keep) points_dropped++;
				if (!exp_v.active) points_passive++;
			end
			default: begin
			end
		endcase
	endtask

	// Compares one result transfer with the oldest outstanding verdict.
	task automatic check_result();
		verdict_t exp_v;
		if (verdicts.size() == 0) begin
			log_mismatch($sformatf("result keep=%b filter_active=%b with no point outstanding",
				keep, filter_active));
		end else begin
			exp_v = verdicts.pop_front();
			if (keep !== exp_v.keep) begin
				log_mismatch($sformatf("keep is %b, expected %b", keep, exp_v.keep));
			end
			if (filter_active !== exp_v.active) begin
				log_mismatch($sformatf("filter_active is %b, expected %b",
					filter_active, exp_v.active));
			end
		end
	endtask

	// Register writes, result transfers, then item transfers, at each edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count = 0;
			age = '0;
			list_seen = 1'b0;
			margin_q = obpr_pkg::MARGIN_RST;
			timeout_q = obpr_pkg::TIMEOUT_RST;
			verdicts.delete();
			fail_count = 0;
			pending = 0;
			points_seen = 0;
			points_dropped = 0;
			points_passive = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == obpr_pkg::REG_MARGIN) begin
					margin_q = pwdata[30:0];
				end else begin
					timeout_q = pwdata;
				end
			end
			if (out_valid && out_ready) begin
				check_result();
			end
			if (in_valid && in_ready) begin
				apply_item();
			end
			pending = verdicts.size();
		end
	end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oriented box point rejector testbench
// Drives box lists, ticks and points into the rejector, with directed corner
// items first and then random lists whose points are aimed in and around the
// stored boxes. The register settings cover the extremes, the receiver and
// sender idle at random, and the checker beside the block scores results.
// ----------------------------------------------------------------------------
module tb;

	localparam int NBOX         = obpr_pkg::MAX_BOXES_DEF;
	localparam int PHASE_ITEMS  = 150;
	localparam int SETTLE       = 8;
	localparam int RUN_LIMIT_NS = 4_000_000;

	// One item as the sender sees it.
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [30:0]        sx;
		logic [30:0]        sy;
		logic [30:0]        sz;
		logic signed [15:0] c;
		logic signed [15:0] s;
	} item_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic [1:0]                   func = obpr_pkg::FUNC_TICK;
	logic signed [31:0]           pos_x = '0;
	logic signed [31:0]           pos_y = '0;
	logic signed [31:0]           pos_z = '0;
	logic [30:0]                  size_x = '0;
	logic [30:0]                  size_y = '0;
	logic [30:0]                  size_z = '0;
	logic signed [15:0]           cos_heading = '0;
	logic signed [15:0]           sin_heading = '0;
	logic                         out_ready = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [obpr_pkg::PADDR_W-1:0] paddr = '0;
	logic [obpr_pkg::PDATA_W-1:0] pwdata = '0;
	logic                         in_ready;
	logic                         out_valid;
	logic                         keep;
	logic                         filter_active;
	logic [obpr_pkg::PDATA_W-1:0] prdata;
	logic                         pready;

	int fail_count;
	int pending;
	int points_seen;
	int points_dropped;
	int points_passive;

	// Stimulus controls and bookkeeping.
	int          send_gap_pct = 12;
	int          recv_stall_pct = 61;
	bit          long_stall_req = 1'b0;
	int          items_sent = 0;
	int          reg_writes = 0;
	logic [30:0] cur_margin = obpr_pkg::MARGIN_RST;
	item_t       aim_box [NBOX];
	int          aim_count = 0;

	oriented_box_point_rejector #(.MAX_BOXES(NBOX)) DUT (.*);

	rejector_checker #(.MAX_BOXES(NBOX)) check (.*);

	// Clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Fills the ignored fields with random bits.
	function automatic item_t op_item(input logic [1:0] kind, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z);
		item_t it;
		it.kind = kind;
		it.x = x;
		it.y = y;
		it.z = z;
		it.sx = 31'($urandom());
		it.sy = 31'($urandom());
		it.sz = 31'($urandom());
		it.c = 16'($urandom());
		it.s = 16'($urandom());
		return it;
	endfunction

	function automatic item_t box_item(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z, input logic [30:0] sx, input logic [30:0] sy,
			input logic [30:0] sz, input logic signed [15:0] c, input logic signed [15:0] s);
		item_t it;
		it = '{obpr_pkg::FUNC_APPEND, x, y, z, sx, sy, sz, c, s};
		return it;
	endfunction

	function automatic logic signed [31:0] near(input int bits);
		return 32'(int'($urandom_range(0, 2 << bits)) - (1 << bits));
	endfunction

	function automatic logic [30:0] pick_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 31'($urandom());
			default: return 31'($urandom_range(1 << 12, 1 << 19));
		endcase
	endfunction

	// Returns {cos, sin}: mostly unit headings, sometimes anything at all.
	function automatic logic [31:0] pick_heading();
		case ($urandom_range(0, 11))
			0: return {16'sd16384, 16'sd0};
			1: return {16'sd0, 16'sd16384};
			2: return {-16'sd16384, 16'sd0};
			3: return {16'sd0, -16'sd16384};
			4: return {16'sd11585, 16'sd11585};
			5: return {-16'sd11585, 16'sd11585};
			6: return {16'sd11585, -16'sd11585};
			7: return {16'sd14189, 16'sd8192};
			8: return {16'sd8192, -16'sd14189};
			9: return {-16'sd15137, -16'sd6270};
			10: return $urandom();
			default: return {16'(int'($urandom_range(0, 32768)) - 16384),
				16'(int'($urandom_range(0, 32768)) - 16384)};
		endcase
	endfunction

	function automatic item_t random_box();
		item_t       it;
		logic [31:0] cs;
		it = op_item(obpr_pkg::FUNC_APPEND, $urandom(), $urandom(), $urandom());
		if ($urandom_range(0, 9) != 0) begin
			cs = pick_heading();
			it.x = near(22);
			it.y = near(22);
			it.z = near(16);
			it.sx = pick_size();
			it.sy = pick_size();
			it.sz = pick_size();
			it.c = cs[31:16];
			it.s = cs[15:0];
		end
		return it;
	endfunction

	// Local offset within a quarter beyond the half-extent plus margin.
	function automatic longint local_offset(input logic [30:0] size);
		longint h, span;
		h = longint'(size) / 2 + longint'(cur_margin);
		span = h + h / 4 + 2;
		return longint'({$urandom(), $urandom()} >> 1) % (2 * span + 1) - span;
	endfunction

	// Points are mostly placed in the frame of a stored box, in and just around it.
	function automatic item_t aimed_point();
		item_t  it, b;
		longint lx, ly, lz, c, s;
		it = op_item(obpr_pkg::FUNC_POINT, $urandom(), $urandom(), $urandom());
		if (aim_count == 0 || $urandom_range(0, 99) < 15) begin
			return it;
		end
		b = aim_box[$urandom_range(0, aim_count - 1)];
		lx = local_offset(b.sx);
		ly = local_offset(b.sy);
		lz = local_offset(b.sz);
		c = longint'($signed(b.c));
		s = longint'($signed(b.s));
		it.x = 32'(longint'($signed(b.x)) + ((lx * c - ly * s) >>> 14));
		it.y = 32'(longint'($signed(b.y)) + ((lx * s + ly * c) >>> 14));
		it.z = 32'(longint'($signed(b.z)) + lz);
		return it;
	endfunction

	// Offers one item after a random gap and holds it until the transfer.
	task automatic send(input item_t it);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= it.kind;
		pos_x <= it.x;
		pos_y <= it.y;
		pos_z <= it.z;
		size_x <= it.sx;
		size_y <= it.sy;
		size_z <= it.sz;
		cos_heading <= it.c;
		sin_heading <= it.s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		// Remember the stored boxes so that later points can aim at them.
		if (it.kind == obpr_pkg::FUNC_START) begin
			aim_count = 0;
		end else if (it.kind == obpr_pkg::FUNC_APPEND && aim_count < NBOX) begin
			aim_box[aim_count] = it;
			aim_count++;
		end
	endtask

	// Stops offering items and waits for every outstanding result.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx == obpr_pkg::REG_MARGIN) begin
			cur_margin = value[30:0];
		end
		reg_writes++;
	endtask

	// Mostly a fresh list with a few boxes and points; sometimes pure noise.
	task automatic run_burst(input int tick_pct);
		int n_box, n_pt, k;
		if ($urandom_range(0, 99) < 12) begin
			for (k = 0; k < 4; k++) begin
				send(op_item(2'($urandom()), $urandom(), $urandom(), $urandom()));
			end
		end else begin
			send(op_item(obpr_pkg::FUNC_START, $urandom(), $urandom(), $urandom()));
			case ($urandom_range(0, 9))
				0: n_box = 0;
				1: n_box = $urandom_range(NBOX, NBOX + 2);
				default: n_box = $urandom_range(1, 6);
			endcase
			for (k = 0; k < n_box; k++) begin
				send(random_box());
			end
			n_pt = $urandom_range(4, 12);
			for (k = 0; k < n_pt; k++) begin
				if ($urandom_range(0, 99) < tick_pct) begin
					send(op_item(obpr_pkg::FUNC_TICK, $urandom(), $urandom(), $urandom()));
				end
				send(aimed_point());
			end
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				out_ready <= 1'b0;
				for (hold = 0; hold < 300; hold++) @(posedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Stimulus.
	initial begin
		int  phase, base, tick_pct;
		bit  stall_issued;
		stall_issued = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner items under the reset register values.
		send(op_item(obpr_pkg::FUNC_POINT, 0, 0, 0));
		send(op_item(obpr_pkg::FUNC_TICK, 0, 0, 0));
		send(op_item(obpr_pkg::FUNC_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		send(op_item(obpr_pkg::FUNC_START, 0, 0, 0));
		send(op_item(obpr_pkg::FUNC_POINT, 0, 0, 0));
		send(box_item(0, 0, 0, 31'd65536, 31'd65536, 31'd65536, 16'sd16384, 16'sd0));
		send(op_item(obpr_pkg::FUNC_POINT, 0, 0, 0));
		// Exactly on the x face, then one step beyond it.
		send(op_item(obpr_pkg::FUNC_POINT, 32'sd39322, 0, 0));
		send(op_item(obpr_pkg::FUNC_POINT, 32'sd39323, 0, 0));
		// Exactly on the y and z faces, then one step above the top face.
		send(op_item(obpr_pkg::FUNC_POINT, 0, -32'sd39322, 32'sd39322));
		send(op_item(obpr_pkg::FUNC_POINT, 0, 0, 32'sd39323));
		send(box_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1, '1,
			-16'sd16384, 16'sd16384));
		// Heading far outside the unit circle.
		send(box_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0,
			16'sh7FFF, 16'sh8000));
		send(op_item(obpr_pkg::FUNC_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		send(op_item(obpr_pkg::FUNC_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		send(box_item(32'sd1048576, 32'sd1048576, 0, 31'd262144, 31'd262144, 31'd262144,
			16'sd11585, 16'sd11585));
		send(op_item(obpr_pkg::FUNC_POINT, 32'sd1114112, 32'sd1114112, 0));
		send(op_item(obpr_pkg::FUNC_TICK, 0, 0, 0));
		send(op_item(obpr_pkg::FUNC_POINT, 32'sd1048576, 32'sd1179648, 0));
		send(op_item(obpr_pkg::FUNC_START, 0, 0, 0));
		send(op_item(obpr_pkg::FUNC_POINT, 0, 0, 0));
		drain();

		// Random traffic over six register settings and three idle patterns.
		for (phase = 0; phase < 6; phase++) begin
			tick_pct = 5;
			case (phase)
				1: begin
					write_reg(obpr_pkg::REG_MARGIN, 32'd0);
					write_reg(obpr_pkg::REG_TIMEOUT, 32'd1000);
				end
				2: begin
					write_reg(obpr_pkg::REG_MARGIN, 32'h7FFF_FFFF);
					write_reg(obpr_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
					send_gap_pct = 61;
					recv_stall_pct = 12;
				end
				3: begin
					// A zero timeout means the list is never fresh.
					write_reg(obpr_pkg::REG_MARGIN, $urandom_range(0, 65536));
					write_reg(obpr_pkg::REG_TIMEOUT, 32'd0);
				end
				4: begin
					write_reg(obpr_pkg::REG_MARGIN, $urandom_range(0, 1 << 15));
					write_reg(obpr_pkg::REG_TIMEOUT, 32'd12);
					send_gap_pct = 0;
					recv_stall_pct = 0;
					tick_pct = 25;
				end
				5: begin
					write_reg(obpr_pkg::REG_MARGIN, {1'b0, obpr_pkg::MARGIN_RST});
					write_reg(obpr_pkg::REG_TIMEOUT, 32'd1);
					tick_pct = 20;
				end
				default: ;
			endcase
			base = items_sent;
			while (items_sent - base < PHASE_ITEMS) begin
				// Hold off the receiver while points keep coming.
				if (phase == 1 && !stall_issued && items_sent - base > 50) begin
					long_stall_req = 1'b1;
					stall_issued = 1'b1;
				end
				run_burst(tick_pct);
			end
			drain();
		end

		repeat (40) @(posedge clk);
		$display("Covered %0d items and %0d register writes, six register settings.",
			items_sent, reg_writes);
		$display("Points checked: %0d, dropped inside a box: %0d, passed unfiltered: %0d.",
			points_seen, points_dropped, points_passive);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#(RUN_LIMIT_NS);
		$display("ERROR: run limit reached with %0d results outstanding", pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
